// ----- sv/dac_pkg.sv -----
// Shared types and constants for the deadlock avoidance checker.
// Used by dac_lane, dac_seq and deadlock_avoidance_checker_core.
package dac_pkg;

    localparam int DEF_MAX_PROCESSES  = 8;
    localparam int DEF_RESOURCE_TYPES = 4;

    localparam int PROC_W      = 3;     // process index field
    localparam int MODE_W      = 3;
    localparam int KIND_W      = 2;
    localparam int AMT_W       = 8;
    localparam int AMT_FIELDS  = 4;     // amounts carried per request
    localparam int AVAIL_W     = 12;
    localparam int AVAIL_MAX   = 4095;
    localparam int PROC_LIMIT  = 8;     // longest safe sequence
    localparam int RES_LIMIT   = 4;
    localparam int CNT_W       = 4;     // holds 0..PROC_LIMIT
    localparam int RCNT_W      = 3;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_PROCESSES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_RESOURCES = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_ALLOC = 3'd0,
        MODE_LOAD_MAX   = 3'd1,
        MODE_SET_AVAIL  = 3'd2,
        MODE_REQUEST    = 3'd3,
        MODE_CHECK      = 3'd4
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_DONE = 2'd0,
        KIND_REJECT    = 2'd1,
        KIND_UNSAFE    = 2'd2,
        KIND_SAFE      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_LOAD_ALLOC,
        LOP_LOAD_MAX,
        LOP_SET_AVAIL,
        LOP_GRANT,
        LOP_WORK_INIT,
        LOP_RELEASE
    } lane_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PREP,
        ST_SCAN,
        ST_REPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        lane_op_t          op;
        logic [PROC_W-1:0] row;
    } lane_ctrl_t;

    typedef struct packed {
        logic req_ok;   // request fits max and available
        logic need_ok;  // need of the addressed row fits the working count
    } lane_stat_t;

endpackage

// ----- sv/dac_lane.sv -----
// One resource column: allocation and maximum entries per process, available
// and working counts. Depends on dac_pkg.
module dac_lane #(
    parameter int ROWS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dac_pkg::lane_ctrl_t       ctrl,
    input  logic                      active,
    input  logic [dac_pkg::AMT_W-1:0] amount,
    output dac_pkg::lane_stat_t       stat
);
    import dac_pkg::*;

    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [AMT_W-1:0]   alloc_reg [ROWS];
    logic [AMT_W-1:0]   max_reg   [ROWS];
    logic [AVAIL_W-1:0] avail_reg;
    logic [AVAIL_W-1:0] work_reg;

    logic [ROW_W-1:0]   idx;
    logic [AMT_W-1:0]   rd_alloc;
    logic [AMT_W-1:0]   rd_max;
    logic [AMT_W:0]     want;
    logic [AMT_W:0]     need;
    logic [AVAIL_W:0]   release_sum;
    logic [AVAIL_W-1:0] work_rel;

    assign idx      = ctrl.row[ROW_W-1:0];
    assign rd_alloc = alloc_reg[idx];
    assign rd_max   = max_reg[idx];

    assign want = {1'b0, rd_alloc} + {1'b0, amount};
    // signed need; negative when allocation was loaded above maximum
    assign need = {1'b0, rd_max} - {1'b0, rd_alloc};

    assign release_sum = {1'b0, work_reg} + (AVAIL_W + 1)'(rd_alloc);
    assign work_rel    = (release_sum > (AVAIL_W + 1)'(AVAIL_MAX)) ?
                         AVAIL_W'(AVAIL_MAX) : release_sum[AVAIL_W-1:0];

    always_comb begin
        stat.req_ok  = !active ||
                       ((want <= {1'b0, rd_max}) && (AVAIL_W'(amount) <= avail_reg));
        stat.need_ok = !active ||
                       ($signed({{(AVAIL_W - AMT_W){need[AMT_W]}}, need}) <=
                        $signed({1'b0, work_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                alloc_reg[r] <= '0;
                max_reg[r]   <= '0;
            end
            avail_reg <= '0;
        end else begin
            case (ctrl.op)
                LOP_LOAD_ALLOC: alloc_reg[idx] <= amount;
                LOP_LOAD_MAX:   max_reg[idx]   <= amount;
                LOP_SET_AVAIL:  avail_reg      <= AVAIL_W'(amount);
                LOP_GRANT: begin
                    if (active) begin
                        alloc_reg[idx] <= want[AMT_W-1:0];
                        avail_reg      <= avail_reg - AVAIL_W'(amount);
                    end
                end
                default: ;
            endcase
        end
    end

    // working count is scratch for the scan, no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.op == LOP_WORK_INIT) begin
            work_reg <= avail_reg;
        end else if (ctrl.op == LOP_RELEASE && active) begin
            work_reg <= work_rel;
        end
    end

endmodule

// ----- sv/dac_seq.sv -----
// Request decoder, safety scan sequencer, lane merge and result register.
// Depends on dac_pkg; drives the dac_lane instances through lane_ctrl_t.
module dac_seq #(
    parameter int MAX_PROCESSES  = dac_pkg::DEF_MAX_PROCESSES,
    parameter int RESOURCE_TYPES = dac_pkg::DEF_RESOURCE_TYPES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [dac_pkg::MODE_W-1:0] in_mode,
    input  logic [dac_pkg::PROC_W-1:0] in_process,
    input  logic [dac_pkg::CNT_W-1:0]  proc_cnt,
    input  dac_pkg::lane_stat_t        lane_stat [RESOURCE_TYPES],
    output dac_pkg::lane_ctrl_t        lane_ctrl,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [dac_pkg::KIND_W-1:0] out_kind,
    output logic [dac_pkg::PROC_W-1:0] out_process,
    output logic                       out_last
);
    import dac_pkg::*;

    state_t              state_reg, state_next;
    mode_t               mode_reg;
    logic [PROC_W-1:0]   proc_reg;
    kind_t               reply_kind_reg, reply_kind_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]    seq_cnt_reg, seq_cnt_next;
    logic [PROC_W-1:0]   emit_idx_reg, emit_idx_next;
    logic [PROC_LIMIT-1:0] done_reg, done_next;
    logic [PROC_W-1:0]   order_reg [PROC_LIMIT];

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [PROC_W-1:0]   out_proc_reg, out_proc_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                out_free;
    logic                all_req_ok;
    logic                all_need_ok;
    logic                finish;
    logic [PROC_W-1:0]   scan_row;

    // merge: a request or a row passes only if every lane agrees
    always_comb begin
        all_req_ok  = 1'b1;
        all_need_ok = 1'b1;
        for (int j = 0; j < RESOURCE_TYPES; j++) begin
            all_req_ok  = all_req_ok  & lane_stat[j].req_ok;
            all_need_ok = all_need_ok & lane_stat[j].need_ok;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign scan_row = scan_idx_reg[PROC_W-1:0];

    always_comb begin
        state_next      = state_reg;
        reply_kind_next = reply_kind_reg;
        scan_idx_next   = scan_idx_reg;
        seq_cnt_next    = seq_cnt_reg;
        emit_idx_next   = emit_idx_reg;
        done_next       = done_reg;
        finish          = 1'b0;
        lane_ctrl.op    = LOP_NONE;
        lane_ctrl.row   = (state_reg == ST_SCAN) ? scan_row : proc_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_proc_next   = out_proc_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                reply_kind_next = KIND_LOAD_DONE;
                state_next      = ST_REPLY;
                unique case (mode_reg)
                    MODE_LOAD_ALLOC: begin
                        if (int'(proc_reg) < MAX_PROCESSES) lane_ctrl.op = LOP_LOAD_ALLOC;
                    end
                    MODE_LOAD_MAX: begin
                        if (int'(proc_reg) < MAX_PROCESSES) lane_ctrl.op = LOP_LOAD_MAX;
                    end
                    MODE_SET_AVAIL: lane_ctrl.op = LOP_SET_AVAIL;
                    MODE_REQUEST: begin
                        if ({1'b0, proc_reg} >= proc_cnt || !all_req_ok) begin
                            reply_kind_next = KIND_REJECT;
                        end else begin
                            lane_ctrl.op = LOP_GRANT;
                            state_next   = ST_PREP;
                        end
                    end
                    MODE_CHECK: state_next = ST_PREP;
                    default: ;
                endcase
            end
            ST_PREP: begin
                lane_ctrl.op  = LOP_WORK_INIT;
                scan_idx_next = '0;
                seq_cnt_next  = '0;
                done_next     = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_idx_reg == proc_cnt) begin
                    emit_idx_next = '0;
                    if (seq_cnt_reg == proc_cnt) begin
                        state_next = ST_EMIT;
                    end else begin
                        reply_kind_next = KIND_UNSAFE;
                        state_next      = ST_REPLY;
                    end
                end else if (!done_reg[scan_row] && all_need_ok) begin
                    // row finishes: release its allocation, restart at process 0
                    finish              = 1'b1;
                    lane_ctrl.op        = LOP_RELEASE;
                    done_next[scan_row] = 1'b1;
                    seq_cnt_next        = seq_cnt_reg + CNT_W'(1);
                    scan_idx_next       = '0;
                end else begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = reply_kind_reg;
                    out_proc_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SAFE;
                    out_proc_next  = order_reg[emit_idx_reg];
                    out_last_next  = ({1'b0, emit_idx_reg} + CNT_W'(1)) == proc_cnt;
                    emit_idx_next  = emit_idx_reg + PROC_W'(1);
                    if (out_last_next) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            scan_idx_reg  <= '0;
            seq_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
            scan_idx_reg  <= scan_idx_next;
            seq_cnt_reg   <= seq_cnt_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(in_mode);
            proc_reg <= in_process;
        end
        if (finish) begin
            order_reg[seq_cnt_reg[PROC_W-1:0]] <= scan_row;
        end
        reply_kind_reg <= reply_kind_next;
        out_kind_reg   <= out_kind_next;
        out_proc_reg   <= out_proc_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_process = out_proc_reg;
    assign out_last    = out_last_reg;

endmodule

// ----- sv/deadlock_avoidance_checker_core.sv -----
// Deadlock avoidance checker (banker's safety check), top level.
// Depends on dac_pkg, dac_lane and dac_seq.
//
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser carries the mode, s_tdata the
//   process and four amounts. Results leave on m_tvalid/m_tready: m_tuser is
//   the result kind, m_tdata the process of a safe sequence entry, m_tlast
//   marks the final result of a request.
//   One request is handled at a time. Row loads and set available give their
//   single result through the decode and reply states. A resource request is
//   checked in the decode state; a granted request or a safety check then runs
//   the scan, one process row per cycle across all resource lanes at once,
//   restarting at process 0 after each finish, then one sequence entry per
//   cycle as the sink takes them. The scan loop sets the rate; the next request
//   is taken once the last result is in the output register.
//   Reset clears all tables, the available counts and the output valid flag;
//   active_processes returns to 8 and active_resources to 4.
//   A stalled sink holds the current result in the output register and the
//   sequencer waits; nothing is dropped.
//   Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at once; the
//   user must make them only while no request is in flight; it is unchecked.
module deadlock_avoidance_checker_core #(
    parameter int MAX_PROCESSES  = dac_pkg::DEF_MAX_PROCESSES,
    parameter int RESOURCE_TYPES = dac_pkg::DEF_RESOURCE_TYPES
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] process, [10:3] amount_a, [18:11] amount_b, [26:19] amount_c,
    // [34:27] amount_d, [39:35] zero
    input  logic [dac_pkg::IN_DATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [dac_pkg::MODE_W-1:0]     s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] sequence_process, [7:3] zero
    output logic [dac_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] kind
    output logic [dac_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast,

    input  logic                           cfg_we,
    input  logic [dac_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dac_pkg::*;

    localparam int ROWS = (MAX_PROCESSES < PROC_LIMIT) ? MAX_PROCESSES : PROC_LIMIT;
    localparam int RLIM = (RESOURCE_TYPES < RES_LIMIT) ? RESOURCE_TYPES : RES_LIMIT;

    logic [CNT_W-1:0]  active_processes_reg;
    logic [RCNT_W-1:0] active_resources_reg;
    logic [CNT_W-1:0]  proc_cnt;
    logic [RCNT_W-1:0] res_cnt;

    logic [AMT_W-1:0]  amt_reg [AMT_FIELDS];
    lane_ctrl_t        lane_ctrl;
    lane_stat_t        lane_stat [RESOURCE_TYPES];
    logic [PROC_W-1:0] out_process;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_processes_reg <= CNT_W'(8);
            active_resources_reg <= RCNT_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ACTIVE_PROCESSES: active_processes_reg <= cfg_wdata[CNT_W-1:0];
                CFG_ACTIVE_RESOURCES: active_resources_reg <= cfg_wdata[RCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp counts to between one and what the tables hold
    always_comb begin
        if (active_processes_reg == '0) proc_cnt = CNT_W'(1);
        else if (active_processes_reg > CNT_W'(ROWS)) proc_cnt = CNT_W'(ROWS);
        else proc_cnt = active_processes_reg;

        if (active_resources_reg == '0) res_cnt = RCNT_W'(1);
        else if (active_resources_reg > RCNT_W'(RLIM)) res_cnt = RCNT_W'(RLIM);
        else res_cnt = active_resources_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int k = 0; k < AMT_FIELDS; k++) begin
                amt_reg[k] <= s_tdata[PROC_W + k*AMT_W +: AMT_W];
            end
        end
    end

    for (genvar j = 0; j < RESOURCE_TYPES; j++) begin : g_lane
        logic [AMT_W-1:0] lane_amt;
        logic             lane_active;

        if (j < AMT_FIELDS) begin : g_amt
            assign lane_amt = amt_reg[j];
        end else begin : g_zero
            assign lane_amt = '0;
        end
        assign lane_active = res_cnt > RCNT_W'(j);

        dac_lane #(
            .ROWS(ROWS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .active  (lane_active),
            .amount  (lane_amt),
            .stat    (lane_stat[j])
        );
    end

    dac_seq #(
        .MAX_PROCESSES  (MAX_PROCESSES),
        .RESOURCE_TYPES (RESOURCE_TYPES)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_process  (s_tdata[PROC_W-1:0]),
        .proc_cnt    (proc_cnt),
        .lane_stat   (lane_stat),
        .lane_ctrl   (lane_ctrl),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_process (out_process),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W - PROC_W){1'b0}}, out_process};

endmodule
